>>> sv/rvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvm_pkg
// widths, fixed-point constants and helpers for the rotation vector to
// matrix core
// ----------------------------------------------------------------------------
package rvm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ANG_GUARD = 11;

	localparam int IN_W  = 20;
	localparam int OUT_W = 18;
	localparam int MAG_W = 20;
	localparam int SQ_W  = 39;
	localparam int SUM_W = 41;
	localparam int A_W   = 31;
	localparam int D_W   = A_W + 1;
	localparam int Q_W   = 31;
	localparam int U_W   = 33;
	localparam int RG_W  = 36;
	localparam int CD_W  = 34;
	localparam int OMC_W = 35;
	localparam int P_W   = 36;
	localparam int E_W   = 37;

	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = Q_W;
	localparam int CD_STEPS  = 30;

	localparam int SQ_SHIFT  = 2 * ANG_GUARD;
	localparam int DIV_SHIFT = 30 + ANG_GUARD + 1;
	localparam int T_SHIFT   = 30 - FRAC_BITS - ANG_GUARD;
	localparam int OUT_SHIFT = 30 - FRAC_BITS;

	typedef logic signed [U_W-1:0]   u_t;
	typedef logic signed [CD_W-1:0]  cd_t;
	typedef logic signed [RG_W-1:0]  rg_t;
	typedef logic signed [P_W-1:0]   p_t;
	typedef logic signed [E_W-1:0]   e_t;
	typedef logic signed [OUT_W-1:0] out_t;

	localparam rg_t PI_Q30      = RG_W'(64'd3373259426);
	localparam rg_t HALF_PI_Q30 = RG_W'(64'd1686629713);
	localparam rg_t TWO_PI_Q30  = RG_W'(64'd6746518852);
	localparam rg_t FOUR_PI_Q30 = RG_W'(64'd13493037704);
	localparam cd_t CORDIC_K_Q30 = CD_W'(64'd652032874);
	localparam logic signed [OMC_W-1:0] ONE_Q30 = OMC_W'(64'd1073741824);

	localparam e_t   OUT_RND = E_W'(1) << (OUT_SHIFT - 1);
	localparam e_t   OUT_LIM = E_W'(1) << FRAC_BITS;
	localparam out_t OUT_ONE = OUT_W'(1) << FRAC_BITS;

	// atan(2^-i) in q30
	function automatic cd_t atan_q30(input logic [4:0] idx);
		cd_t r;
		case (idx)
			5'd0:  r = CD_W'(64'd843314856);
			5'd1:  r = CD_W'(64'd497837829);
			5'd2:  r = CD_W'(64'd263043836);
			5'd3:  r = CD_W'(64'd133525158);
			5'd4:  r = CD_W'(64'd67021687);
			5'd5:  r = CD_W'(64'd33543515);
			5'd6:  r = CD_W'(64'd16775850);
			5'd7:  r = CD_W'(64'd8388437);
			5'd8:  r = CD_W'(64'd4194282);
			5'd9:  r = CD_W'(64'd2097149);
			5'd10: r = CD_W'(64'd1048575);
			5'd11: r = CD_W'(64'd524287);
			5'd12: r = CD_W'(64'd262143);
			5'd13: r = CD_W'(64'd131071);
			5'd14: r = CD_W'(64'd65535);
			5'd15: r = CD_W'(64'd32767);
			5'd16: r = CD_W'(64'd16383);
			5'd17: r = CD_W'(64'd8191);
			5'd18: r = CD_W'(64'd4095);
			5'd19: r = CD_W'(64'd2047);
			5'd20: r = CD_W'(64'd1023);
			5'd21: r = CD_W'(64'd511);
			5'd22: r = CD_W'(64'd255);
			5'd23: r = CD_W'(64'd127);
			5'd24: r = CD_W'(64'd63);
			5'd25: r = CD_W'(64'd31);
			5'd26: r = CD_W'(64'd15);
			5'd27: r = CD_W'(64'd8);
			5'd28: r = CD_W'(64'd4);
			5'd29: r = CD_W'(64'd2);
			default: r = '0;
		endcase
		return r;
	endfunction

	// round q30 to the output format and clamp to plus or minus one
	function automatic out_t to_out(input e_t e);
		e_t r;
		r = (e + OUT_RND) >>> OUT_SHIFT;
		if (r > OUT_LIM) begin
			r = OUT_LIM;
		end else if (r < -OUT_LIM) begin
			r = -OUT_LIM;
		end
		return OUT_W'(r);
	endfunction

endpackage

>>> sv/rotation_vector_to_matrix_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_vector_to_matrix_core
// rotation vector (q3.16) to 3x3 rotation matrix (q1.16) by rodrigues' formula
// ----------------------------------------------------------------------------
// One item enters per clock while the output side does not stall, and every
// item leaves in order, one result item per input item. The bulk of the
// pipeline is three step-per-stage units: a 32-stage integer square
// root for the angle, a 31-stage restoring divider that normalizes the axis
// (three lanes), and a 30-stage cordic for cos and sin that runs beside the
// divider, then three stages for the outer products, the scaling multiplies
// and the final rounding and clamp. The whole pipeline freezes while a
// finished result is held by out_stall; in_stall is then high. A zero vector
// gives the identity.
// ----------------------------------------------------------------------------
module rotation_vector_to_matrix_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [rvm_pkg::IN_W-1:0]  rot_x,
	input  logic signed [rvm_pkg::IN_W-1:0]  rot_y,
	input  logic signed [rvm_pkg::IN_W-1:0]  rot_z,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [rvm_pkg::OUT_W-1:0] m00,
	output logic signed [rvm_pkg::OUT_W-1:0] m01,
	output logic signed [rvm_pkg::OUT_W-1:0] m02,
	output logic signed [rvm_pkg::OUT_W-1:0] m10,
	output logic signed [rvm_pkg::OUT_W-1:0] m11,
	output logic signed [rvm_pkg::OUT_W-1:0] m12,
	output logic signed [rvm_pkg::OUT_W-1:0] m20,
	output logic signed [rvm_pkg::OUT_W-1:0] m21,
	output logic signed [rvm_pkg::OUT_W-1:0] m22
);
	import rvm_pkg::*;

	// positions of the stages in the valid chain (bit 0 is stage s1)
	localparam int RT0_IDX    = 2;
	localparam int RT_END     = RT0_IDX + SQ_STEPS;
	localparam int DV0_IDX    = RT_END + 1;
	localparam int DV_END     = DV0_IDX + DIV_STEPS;
	localparam int CD_END     = DV0_IDX + 4 + CD_STEPS;
	localparam int PIPE_DEPTH = CD_END + 4;

	// global advance: everything moves unless a finished item is held
	logic en;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	// ---------------- s1: input capture
	logic signed [IN_W-1:0] v_s1 [0:2];

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1[0] <= rot_x;
			v_s1[1] <= rot_y;
			v_s1[2] <= rot_z;
		end
	end

	// ---------------- s2: squares, magnitudes and signs
	logic [SQ_W-1:0]  sqv_s2 [0:2];
	logic [MAG_W-1:0] mag_s2 [0:2];
	logic [2:0]       neg_s2;

	for (genvar i = 0; i < 3; i++) begin : g_sq
		logic signed [2*IN_W-1:0] prod;
		assign prod = v_s1[i] * v_s1[i];
		always_ff @(posedge clk) begin
			if (en) begin
				sqv_s2[i] <= SQ_W'(prod);
				mag_s2[i] <= v_s1[i][IN_W-1] ? MAG_W'(-v_s1[i]) : MAG_W'(v_s1[i]);
				neg_s2[i] <= v_s1[i][IN_W-1];
			end
		end
	end

	// ---------------- s3 and on: squared norm, then the square root
	// restoring square root, one result bit per stage
	logic [63:0]      rt_n_s [0:SQ_STEPS];
	logic [63:0]      rt_r_s [0:SQ_STEPS];
	logic [MAG_W-1:0] rt_m_s [0:SQ_STEPS][0:2];
	logic [2:0]       rt_g_s [0:SQ_STEPS];
	logic             rt_z_s [0:SQ_STEPS];
	logic [SUM_W-1:0] sum_s2;

	assign sum_s2 = SUM_W'(sqv_s2[0]) + SUM_W'(sqv_s2[1]) + SUM_W'(sqv_s2[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			rt_n_s[0] <= 64'({sum_s2, {SQ_SHIFT{1'b0}}});
			rt_r_s[0] <= '0;
			rt_m_s[0] <= mag_s2;
			rt_g_s[0] <= neg_s2;
			rt_z_s[0] <= (sum_s2 == '0);
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_rt
		localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
		logic [63:0] trial;
		assign trial = rt_r_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rt_n_s[k] >= trial) begin
					rt_n_s[k+1] <= rt_n_s[k] - trial;
					rt_r_s[k+1] <= (rt_r_s[k] >> 1) + BIT;
				end else begin
					rt_n_s[k+1] <= rt_n_s[k];
					rt_r_s[k+1] <= rt_r_s[k] >> 1;
				end
				rt_m_s[k+1] <= rt_m_s[k];
				rt_g_s[k+1] <= rt_g_s[k];
				rt_z_s[k+1] <= rt_z_s[k];
			end
		end
	end

	// angle at scale 2^(frac+11)
	logic [A_W-1:0] ang;
	assign ang = rt_r_s[SQ_STEPS][A_W-1:0];

	// ---------------- axis normalization: three restoring dividers
	// u = round(|v| * 2^41 / a) computed as (|v|*2^42 + a) / (2a)
	logic [D_W-1:0] dv_d_s [0:DIV_STEPS];
	logic [63:0]    dv_r_s [0:DIV_STEPS][0:2];
	logic [Q_W-1:0] dv_q_s [0:DIV_STEPS][0:2];
	logic [2:0]     dv_g_s [0:DIV_STEPS];
	logic           dv_z_s [0:DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_d_s[0] <= {ang, 1'b0};
			for (int i = 0; i < 3; i++) begin
				dv_r_s[0][i] <= (64'(rt_m_s[SQ_STEPS][i]) << DIV_SHIFT) + 64'(ang);
				dv_q_s[0][i] <= '0;
			end
			dv_g_s[0] <= rt_g_s[SQ_STEPS];
			dv_z_s[0] <= rt_z_s[SQ_STEPS];
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
		localparam int P = DIV_STEPS - 1 - k;
		logic [63:0] dsh;
		assign dsh = 64'(dv_d_s[k]) << P;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (dv_r_s[k][i] >= dsh) begin
						dv_r_s[k+1][i] <= dv_r_s[k][i] - dsh;
						dv_q_s[k+1][i] <= dv_q_s[k][i] | (Q_W'(1) << P);
					end else begin
						dv_r_s[k+1][i] <= dv_r_s[k][i];
						dv_q_s[k+1][i] <= dv_q_s[k][i];
					end
				end
				dv_d_s[k+1] <= dv_d_s[k];
				dv_g_s[k+1] <= dv_g_s[k];
				dv_z_s[k+1] <= dv_z_s[k];
			end
		end
	end

	// signed axis, delayed to line up with the cordic output
	u_t   ud_u_s [1:3][0:2];
	logic ud_z_s [1:3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ud_u_s[1][i] <= dv_g_s[DIV_STEPS][i] ? -U_W'(dv_q_s[DIV_STEPS][i])
					: U_W'(dv_q_s[DIV_STEPS][i]);
			end
			ud_z_s[1] <= dv_z_s[DIV_STEPS];
			ud_u_s[2] <= ud_u_s[1];
			ud_z_s[2] <= ud_z_s[1];
			ud_u_s[3] <= ud_u_s[2];
			ud_z_s[3] <= ud_z_s[2];
		end
	end

	// ---------------- angle reduction into (-pi, pi]
	// the angle stays below three turns, so two conditional subtracts give
	// the remainder modulo two pi
	rg_t rg_t_s [0:3];

	always_ff @(posedge clk) begin
		if (en) begin
			rg_t_s[0] <= RG_W'({1'b0, ang}) << T_SHIFT;
			rg_t_s[1] <= (rg_t_s[0] >= FOUR_PI_Q30) ? rg_t_s[0] - FOUR_PI_Q30 : rg_t_s[0];
			rg_t_s[2] <= (rg_t_s[1] >= TWO_PI_Q30) ? rg_t_s[1] - TWO_PI_Q30 : rg_t_s[1];
			rg_t_s[3] <= (rg_t_s[2] > PI_Q30) ? rg_t_s[2] - TWO_PI_Q30 : rg_t_s[2];
		end
	end

	// ---------------- cordic, rotation mode, one micro-rotation per stage
	cd_t  cd_x_s [0:CD_STEPS];
	cd_t  cd_y_s [0:CD_STEPS];
	cd_t  cd_z_s [0:CD_STEPS];
	logic cd_n_s [0:CD_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			cd_x_s[0] <= CORDIC_K_Q30;
			cd_y_s[0] <= '0;
			// outside the right half plane: move by pi and negate the result
			if (rg_t_s[3] > HALF_PI_Q30) begin
				cd_z_s[0] <= CD_W'(rg_t_s[3] - PI_Q30);
				cd_n_s[0] <= 1'b1;
			end else if (rg_t_s[3] < -HALF_PI_Q30) begin
				cd_z_s[0] <= CD_W'(rg_t_s[3] + PI_Q30);
				cd_n_s[0] <= 1'b1;
			end else begin
				cd_z_s[0] <= CD_W'(rg_t_s[3]);
				cd_n_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < CD_STEPS; i++) begin : g_cd
		localparam cd_t ATAN = atan_q30(5'(i));
		cd_t xs;
		cd_t ys;
		assign xs = cd_x_s[i] >>> i;
		assign ys = cd_y_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cd_z_s[i][CD_W-1]) begin
					cd_x_s[i+1] <= cd_x_s[i] - ys;
					cd_y_s[i+1] <= cd_y_s[i] + xs;
					cd_z_s[i+1] <= cd_z_s[i] - ATAN;
				end else begin
					cd_x_s[i+1] <= cd_x_s[i] + ys;
					cd_y_s[i+1] <= cd_y_s[i] - xs;
					cd_z_s[i+1] <= cd_z_s[i] + ATAN;
				end
				cd_n_s[i+1] <= cd_n_s[i];
			end
		end
	end

	// ---------------- s71: outer products, cross-product terms, 1 - cos
	u_t                        uu_s71 [0:8];
	u_t                        k_s71  [0:8];
	logic signed [OMC_W-1:0]   omc_s71;
	cd_t                       c_s71;
	cd_t                       s_s71;
	logic                      zero_s71;
	cd_t                       cos_v;
	cd_t                       sin_v;

	assign cos_v = cd_n_s[CD_STEPS] ? -cd_x_s[CD_STEPS] : cd_x_s[CD_STEPS];
	assign sin_v = cd_n_s[CD_STEPS] ? -cd_y_s[CD_STEPS] : cd_y_s[CD_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			omc_s71  <= ONE_Q30 - OMC_W'(cos_v);
			c_s71    <= cos_v;
			s_s71    <= sin_v;
			zero_s71 <= ud_z_s[3];
		end
	end

	for (genvar e = 0; e < 9; e++) begin : g_m1
		localparam int RI   = e / 3;
		localparam int CJ   = e % 3;
		// the diagonal has no cross-product term; keep its lane index in range
		localparam int KSRC = (RI == CJ) ? 0 : 3 - RI - CJ;
		localparam bit KNEG = (((CJ - RI + 3) % 3) == 1);
		logic signed [2*U_W-1:0] prod;
		assign prod = ud_u_s[3][RI] * ud_u_s[3][CJ];
		always_ff @(posedge clk) begin
			if (en) begin
				uu_s71[e] <= U_W'(prod >>> 30);
				if (RI == CJ) begin
					k_s71[e] <= '0;
				end else if (KNEG) begin
					k_s71[e] <= -ud_u_s[3][KSRC];
				end else begin
					k_s71[e] <= ud_u_s[3][KSRC];
				end
			end
		end
	end

	// ---------------- s72: (1 - cos) * u u^T and sin * [u]x
	p_t   pa_s72 [0:8];
	p_t   pb_s72 [0:8];
	cd_t  c_s72;
	logic zero_s72;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s72    <= c_s71;
			zero_s72 <= zero_s71;
		end
	end

	for (genvar e = 0; e < 9; e++) begin : g_m2
		logic signed [OMC_W+U_W-1:0] pa;
		logic signed [CD_W+U_W-1:0]  pb;
		assign pa = omc_s71 * uu_s71[e];
		assign pb = s_s71 * k_s71[e];
		always_ff @(posedge clk) begin
			if (en) begin
				pa_s72[e] <= P_W'(pa >>> 30);
				pb_s72[e] <= P_W'(pb >>> 30);
			end
		end
	end

	// ---------------- s73: sum, round, clamp; zero vector gives identity
	out_t out_s73 [0:8];

	for (genvar e = 0; e < 9; e++) begin : g_m3
		localparam bit DIAG = ((e / 3) == (e % 3));
		e_t esum;
		assign esum = E_W'(pa_s72[e]) + E_W'(pb_s72[e]) + (DIAG ? E_W'(c_s72) : E_W'(0));
		always_ff @(posedge clk) begin
			if (en) begin
				if (zero_s72) begin
					out_s73[e] <= DIAG ? OUT_ONE : '0;
				end else begin
					out_s73[e] <= to_out(esum);
				end
			end
		end
	end

	assign m00 = out_s73[0];
	assign m01 = out_s73[1];
	assign m02 = out_s73[2];
	assign m10 = out_s73[3];
	assign m11 = out_s73[4];
	assign m12 = out_s73[5];
	assign m20 = out_s73[6];
	assign m21 = out_s73[7];
	assign m22 = out_s73[8];

`ifndef NO_ASSERTIONS
	// every delivered entry lies within plus or minus one
	for (genvar e = 0; e < 9; e++) begin : g_chk_out
		a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
			out_valid |-> (out_s73[e] <= OUT_ONE && out_s73[e] >= -OUT_ONE))
			else $error("matrix entry out of range");
	end

	// the angle fits its register after the square root
	a_sqrt_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[RT_END] |-> (rt_r_s[SQ_STEPS][63:A_W] == '0))
		else $error("square root result too wide");

	// divider remainders end below the divisor for a nonzero vector
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[DV_END] && !dv_z_s[DIV_STEPS]) |->
		(dv_r_s[DIV_STEPS][0] < 64'(dv_d_s[DIV_STEPS]) &&
		 dv_r_s[DIV_STEPS][1] < 64'(dv_d_s[DIV_STEPS]) &&
		 dv_r_s[DIV_STEPS][2] < 64'(dv_d_s[DIV_STEPS])))
		else $error("divider remainder not reduced");

	// the cordic angle residue has converged
	a_cordic_conv: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[CD_END] |-> (cd_z_s[CD_STEPS] < CD_W'(16) && cd_z_s[CD_STEPS] > -CD_W'(16)))
		else $error("cordic did not converge");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for rotation_vector_to_matrix_core: a directed table,
// then random rotation vectors with random idling on both sides; every result
// matrix is compared with a typed-in one or a bit-exact rodrigues predictor
// ----------------------------------------------------------------------------
module tb;

	import rvm_pkg::*;

	localparam int N_RANDOM  = 1750;
	localparam int LATENCY   = 73;
	localparam int N_TABLE   = 20;
	localparam longint ONE30 = 64'sd1073741824;
	localparam longint PI30  = 64'sd3373259426;
	localparam longint HPI30 = 64'sd1686629713;
	localparam longint TPI30 = 64'sd6746518852;

	typedef struct packed {
		logic signed [OUT_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	} matrix_t;

	typedef struct packed {
		logic signed [IN_W-1:0] x, y, z;
		logic                   known;  // expected matrix typed in below
		matrix_t                m;
	} vec_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [IN_W-1:0] rot_x = '0, rot_y = '0, rot_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	matrix_t expected_matrices[$];
	int      n_mismatch = 0;
	int      n_checked = 0;
	int      n_sent = 0;
	int      n_unexpected = 0;
	bit      stim_done = 1'b0;
	bit      hold_off = 1'b0;

	vec_row_t vec_table[N_TABLE];

	rotation_vector_to_matrix_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.m00(m00), .m01(m01), .m02(m02),
		.m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// floor shift of a signed value
	function automatic longint fshr(input longint v, input int s);
		return v >>> s;
	endfunction

	// integer square root, bit by bit
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint atan_entry(input int i);
		longint tbl[30] = '{843314856, 497837829, 263043836, 133525158, 67021687,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
			262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
			255, 127, 63, 31, 15, 8, 4, 2};
		return tbl[i];
	endfunction

	// q30 result entry to the rounded, clamped output format
	function automatic logic signed [OUT_W-1:0] round_clamp(input longint q);
		longint v, lim;
		lim = 64'sd1 << FRAC_BITS;
		v = fshr(q + (64'sd1 << (29 - FRAC_BITS)), 30 - FRAC_BITS);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return OUT_W'(v);
	endfunction

	// rodrigues rotation matrix of one rotation vector
	function automatic matrix_t rodrigues(input logic signed [IN_W-1:0] x,
			input logic signed [IN_W-1:0] y, input logic signed [IN_W-1:0] z);
		longint v[3], u[3], k[3][3], ent[9];
		longint cx, sy, zz, xn, t, uu, e;
		longint unsigned sq, a, mag, q;
		bit neg;
		matrix_t r;
		v[0] = x;
		v[1] = y;
		v[2] = z;
		sq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
		if (sq == 0) begin
			r = '0;
			r.e00 = OUT_ONE;
			r.e11 = OUT_ONE;
			r.e22 = OUT_ONE;
			return r;
		end
		a = int_sqrt(sq << (2 * ANG_GUARD));
		t = longint'(a << (30 - FRAC_BITS - ANG_GUARD));
		for (int i = 0; i < 3; i++) begin
			mag = v[i] < 0 ? -v[i] : v[i];
			q = ((mag << (30 + ANG_GUARD + 1)) + a) / (2 * a);
			u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		// angle into (-pi, pi], then fold into the cordic's range
		t = t % TPI30;
		if (t > PI30) t -= TPI30;
		neg = 1'b0;
		if (t > HPI30) begin
			t -= PI30;
			neg = 1'b1;
		end else if (t < -HPI30) begin
			t += PI30;
			neg = 1'b1;
		end
		cx = 64'sd652032874;
		sy = 0;
		zz = t;
		for (int i = 0; i < 30; i++) begin
			if (zz >= 0) begin
				xn = cx - fshr(sy, i);
				sy = sy + fshr(cx, i);
				zz -= atan_entry(i);
			end else begin
				xn = cx + fshr(sy, i);
				sy = sy - fshr(cx, i);
				zz += atan_entry(i);
			end
			cx = xn;
		end
		if (neg) begin
			cx = -cx;
			sy = -sy;
		end
		k[0][0] = 0;     k[0][1] = -u[2]; k[0][2] = u[1];
		k[1][0] = u[2];  k[1][1] = 0;     k[1][2] = -u[0];
		k[2][0] = -u[1]; k[2][1] = u[0];  k[2][2] = 0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				uu = fshr(u[i] * u[j], 30);
				e = fshr((ONE30 - cx) * uu, 30) + fshr(sy * k[i][j], 30);
				if (i == j) e += cx;
				ent[i * 3 + j] = e;
			end
		end
		r.e00 = round_clamp(ent[0]); r.e01 = round_clamp(ent[1]);
		r.e02 = round_clamp(ent[2]); r.e10 = round_clamp(ent[3]);
		r.e11 = round_clamp(ent[4]); r.e12 = round_clamp(ent[5]);
		r.e20 = round_clamp(ent[6]); r.e21 = round_clamp(ent[7]);
		r.e22 = round_clamp(ent[8]);
		return r;
	endfunction

	function automatic vec_row_t row(input int x, input int y, input int z);
		vec_row_t r;
		r = '0;
		r.x = IN_W'(x);
		r.y = IN_W'(y);
		r.z = IN_W'(z);
		return r;
	endfunction

	function automatic vec_row_t row_known(input int x, input int y, input int z,
			input matrix_t m);
		vec_row_t r;
		r = row(x, y, z);
		r.known = 1'b1;
		r.m = m;
		return r;
	endfunction

	// directed vectors: zero, extremes, half turns, smallest steps, each axis
	initial begin
		matrix_t ident;
		ident = '0;
		ident.e00 = OUT_ONE;
		ident.e11 = OUT_ONE;
		ident.e22 = OUT_ONE;
		vec_table[0]  = row_known(0, 0, 0, ident);
		vec_table[1]  = row(1, 0, 0);
		vec_table[2]  = row(0, -1, 0);
		vec_table[3]  = row(0, 0, 1);
		vec_table[4]  = row(524287, 524287, 524287);
		vec_table[5]  = row(-524288, -524288, -524288);
		vec_table[6]  = row(524287, -524288, 0);
		vec_table[7]  = row(-524288, 0, 524287);
		vec_table[8]  = row(205887, 0, 0);      // about pi
		vec_table[9]  = row(0, -205887, 0);
		vec_table[10] = row(0, 0, 102944);      // about pi/2
		vec_table[11] = row(411775, 0, 0);      // about 2 pi
		vec_table[12] = row(65536, 65536, 65536);
		vec_table[13] = row(-1, -1, -1);
		vec_table[14] = row(-524288, 0, 0);
		vec_table[15] = row(0, 524287, 0);
		vec_table[16] = row(0, 0, -524288);
		vec_table[17] = row(21845, -43690, 349525);
		vec_table[18] = row(-349526, 174762, -87381);
		vec_table[19] = row_known(0, 0, 0, ident);
	end

	task automatic report_mismatch(input matrix_t want, input matrix_t got);
		n_mismatch++;
		if (n_mismatch <= 10)
			$display("mismatch at result %0d: expected %p actual %p",
				n_checked, want, got);
	endtask

	// hand one vector to the block and wait for its acceptance; called and
	// returning at a falling edge, valid stays high into a gapless next item
	task automatic send_vector(input logic signed [IN_W-1:0] x,
			input logic signed [IN_W-1:0] y, input logic signed [IN_W-1:0] z,
			input bit known, input matrix_t m);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) gap = 0;  // stretches with no idling
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rot_x <= x;
		rot_y <= y;
		rot_z <= z;
		in_valid <= 1'b1;
		// the expectation enters before the result can possibly appear
		expected_matrices.push_back(known ? m : rodrigues(x, y, z));
		do @(posedge clk); while (in_stall);
		n_sent++;
		@(negedge clk);
	endtask

	// random vector: mostly plain angles, sometimes tiny or extreme components
	function automatic logic signed [IN_W-1:0] rand_comp();
		case ($urandom_range(0, 7))
			0:       return IN_W'($urandom_range(0, 15)) - IN_W'(8);
			1:       return $urandom_range(0, 1) ? IN_W'(524287) : IN_W'(-524288);
			2:       return '0;
			default: return IN_W'($urandom);
		endcase
	endfunction

	// sender
	initial begin
		matrix_t none;
		none = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		for (int i = 0; i < N_TABLE; i++)
			send_vector(vec_table[i].x, vec_table[i].y, vec_table[i].z,
				vec_table[i].known, vec_table[i].m);
		for (int i = 0; i < N_RANDOM; i++)
			send_vector(rand_comp(), rand_comp(), rand_comp(), 1'b0, none);
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver stall pattern, with one long hold-off to fill the pipeline
	initial begin
		int wait_cycles;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (n_sent >= 300 && n_sent < 320 && !hold_off) begin
				hold_off = 1'b1;
				out_stall <= 1'b1;
				repeat (200) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				wait_cycles = $urandom_range(0, 9);
				if ($urandom_range(0, 3) == 0) wait_cycles = 0;
				if (wait_cycles != 0) begin
					out_stall <= 1'b1;
					repeat (wait_cycles - 1) @(negedge clk);
					@(negedge clk);
				end
				out_stall <= 1'b0;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		matrix_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			if (expected_matrices.size() == 0) begin
				n_unexpected++;
				n_mismatch++;
				if (n_mismatch <= 10) $display("result with no input waiting: %p", got);
			end else begin
				want = expected_matrices.pop_front();
				if (got !== want) report_mismatch(want, got);
				n_checked++;
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (expected_matrices.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("sent %0d rotation vectors (%0d directed), checked %0d matrices",
			n_sent, N_TABLE, n_checked);
		$display("pipeline was filled by one long output hold-off; %0d mismatches, %0d unexpected",
			n_mismatch, n_unexpected);
		if (n_mismatch == 0 && expected_matrices.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// timeout
	initial begin
		#1000000;
		$display("timeout");
		$display("tb NOT OK");
		$finish;
	end

endmodule
